/* hw/rtl/protobuf_wire_field_parser_core_macros.svh */
// Assertion macros for the protobuf wire field parser checker.
// Depends on: a clk and an active-low arst_n in the scope of use.
`ifndef PROTOBUF_WIRE_FIELD_PARSER_CORE_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PWF_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PWF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pwf_pkg.sv */
// Shared types, codes and constants for the protobuf wire field parser.
// No dependencies.
package pwf_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 112;
	localparam int OUT_TUSER_W = 3;

	localparam logic [2:0] KIND_VARINT  = 3'd0;
	localparam logic [2:0] KIND_HEADER  = 3'd1;
	localparam logic [2:0] KIND_PAYLOAD = 3'd2;
	localparam logic [2:0] KIND_END     = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_ZERO_FIELD = 3'd1;
	localparam logic [2:0] ERR_WIRE_TYPE  = 3'd2;
	localparam logic [2:0] ERR_LONG_VAR   = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED  = 3'd4;
	localparam logic [2:0] ERR_LEN_BIG    = 3'd5;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] tag_num;
		logic [2:0]  wt_code;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [2:0]  error_code;
	} pwf_result_t;

	typedef struct packed {
		logic [1:0]  count;
		pwf_result_t r0;
		pwf_result_t r1;
	} pwf_pair_t;

	function automatic pwf_result_t mk_result(logic [2:0] kind, logic [31:0] fnum,
			logic [2:0] wtype, logic [63:0] value, logic [7:0] pbyte, logic plast,
			logic [2:0] err);
		pwf_result_t r;
		r.kind         = kind;
		r.tag_num      = fnum;
		r.wt_code      = wtype;
		r.value        = value;
		r.payload_byte = pbyte;
		r.payload_last = plast;
		r.error_code   = err;
		return r;
	endfunction

	function automatic pwf_result_t end_result();
		return mk_result(KIND_END, '0, '0, '0, '0, 1'b0, ERR_NONE);
	endfunction

endpackage

/* hw/rtl/pwf_decode.sv */
// Decode state and per-byte decode logic: key, varint, length and payload phases.
// Depends on: pwf_pkg.
module pwf_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        in_byte,
	input  logic              in_final,
	output pwf_pkg::pwf_pair_t pair
);
	import pwf_pkg::*;

	localparam logic [1:0] PH_KEY     = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_LENGTH  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	logic [1:0]             phase_q, phase_n;
	logic [63:0]            acc_q, acc_n;
	logic [3:0]             cnt_q, cnt_n;
	logic [31:0]            fn_q, fn_n;
	logic [2:0]             wt_q, wt_n;
	logic [LENGTH_BITS-1:0] rem_q, rem_n;
	logic                   err_q, err_n;

	logic [6:0]             shamt7;
	logic [63:0]            acc_new;
	logic [3:0]             cnt_new;
	logic [LENGTH_BITS-1:0] rem_dec;
	logic                   last;
	logic                   len_big;
	logic                   err_set;

	assign shamt7  = {3'b000, cnt_q} * 7'd7;
	assign acc_new = acc_q | ({57'd0, in_byte[6:0]} << shamt7[5:0]);
	assign cnt_new = cnt_q + 4'd1;
	assign rem_dec = (rem_q == '0) ? '0 : rem_q - LENGTH_BITS'(1);
	assign last    = (rem_dec == '0);
	assign len_big = ((acc_new >> LENGTH_BITS) != 64'd0);

	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		fn_n    = fn_q;
		wt_n    = wt_q;
		rem_n   = rem_q;
		err_n   = err_q;
		err_set = 1'b0;
		pair    = '0;
		if (err_q) begin
			pair.count = 2'd0;
		end else if (phase_q == PH_PAYLOAD) begin
			rem_n   = rem_dec;
			pair.r0 = mk_result(KIND_PAYLOAD, fn_q, wt_q, '0, in_byte, last, ERR_NONE);
			pair.count = 2'd1;
			if (last) begin
				phase_n = PH_KEY;
				if (in_final) begin
					pair.r1    = end_result();
					pair.count = 2'd2;
				end
			end else if (in_final) begin
				pair.r1    = mk_result(KIND_ERROR, fn_q, wt_q, '0, '0, 1'b0, ERR_TRUNCATED);
				pair.count = 2'd2;
			end
		end else if (in_byte[7]) begin
			acc_n = acc_new;
			cnt_n = cnt_new;
			if (cnt_new >= VARINT_MAX_BYTES) begin
				pair.r0    = mk_result(KIND_ERROR, fn_q, wt_q, '0, '0, 1'b0, ERR_LONG_VAR);
				pair.count = 2'd1;
				err_set    = 1'b1;
			end else if (in_final) begin
				pair.r0    = mk_result(KIND_ERROR, fn_q, wt_q, '0, '0, 1'b0, ERR_TRUNCATED);
				pair.count = 2'd1;
			end
		end else begin
			acc_n = '0;
			cnt_n = '0;
			case (phase_q)
				PH_KEY: begin
					fn_n = acc_new[34:3];
					wt_n = acc_new[2:0];
					if (fn_n == '0) begin
						pair.r0    = mk_result(KIND_ERROR, fn_n, wt_n, '0, '0, 1'b0,
							ERR_ZERO_FIELD);
						pair.count = 2'd1;
						err_set    = 1'b1;
					end else if (wt_n == WT_VARINT || wt_n == WT_LEN) begin
						phase_n = (wt_n == WT_VARINT) ? PH_VALUE : PH_LENGTH;
						if (in_final) begin
							pair.r0    = mk_result(KIND_ERROR, fn_n, wt_n, '0, '0, 1'b0,
								ERR_TRUNCATED);
							pair.count = 2'd1;
						end
					end else if (wt_n == WT_FIXED64 || wt_n == WT_FIXED32) begin
						rem_n   = (wt_n == WT_FIXED64) ? LENGTH_BITS'(8) : LENGTH_BITS'(4);
						phase_n = PH_PAYLOAD;
						pair.r0 = mk_result(KIND_HEADER, fn_n, wt_n,
							(wt_n == WT_FIXED64) ? 64'd8 : 64'd4, '0, 1'b0, ERR_NONE);
						pair.count = 2'd1;
						if (in_final) begin
							pair.r1    = mk_result(KIND_ERROR, fn_n, wt_n, '0, '0, 1'b0,
								ERR_TRUNCATED);
							pair.count = 2'd2;
						end
					end else begin
						pair.r0    = mk_result(KIND_ERROR, fn_n, wt_n, '0, '0, 1'b0,
							ERR_WIRE_TYPE);
						pair.count = 2'd1;
						err_set    = 1'b1;
					end
				end
				PH_VALUE: begin
					phase_n    = PH_KEY;
					pair.r0    = mk_result(KIND_VARINT, fn_q, wt_q, acc_new, '0, 1'b0,
						ERR_NONE);
					pair.count = 2'd1;
					if (in_final) begin
						pair.r1    = end_result();
						pair.count = 2'd2;
					end
				end
				default: begin
					if (len_big) begin
						pair.r0    = mk_result(KIND_ERROR, fn_q, wt_q, '0, '0, 1'b0,
							ERR_LEN_BIG);
						pair.count = 2'd1;
						err_set    = 1'b1;
					end else begin
						pair.r0    = mk_result(KIND_HEADER, fn_q, wt_q, acc_new, '0, 1'b0,
							ERR_NONE);
						pair.count = 2'd1;
						if (acc_new == 64'd0) begin
							phase_n = PH_KEY;
							if (in_final) begin
								pair.r1    = end_result();
								pair.count = 2'd2;
							end
						end else begin
							rem_n   = acc_new[LENGTH_BITS-1:0];
							phase_n = PH_PAYLOAD;
							if (in_final) begin
								pair.r1    = mk_result(KIND_ERROR, fn_q, wt_q, '0, '0,
									1'b0, ERR_TRUNCATED);
								pair.count = 2'd2;
							end
						end
					end
				end
			endcase
		end
		if (err_set) begin
			err_n = 1'b1;
		end
		// return to reset state at end of message
		if (in_final) begin
			phase_n = PH_KEY;
			acc_n   = '0;
			cnt_n   = '0;
			fn_n    = '0;
			wt_n    = '0;
			rem_n   = '0;
			err_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_q   <= '0;
			cnt_q   <= '0;
			fn_q    <= '0;
			wt_q    <= '0;
			rem_q   <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			fn_q    <= fn_n;
			wt_q    <= wt_n;
			rem_q   <= rem_n;
			err_q   <= err_n;
		end
	end

endmodule

/* hw/rtl/pwf_out_buf.sv */
// Two-entry result register: holds up to two results of one byte, emits in order.
// Depends on: pwf_pkg.
module pwf_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  pwf_pkg::pwf_pair_t   pair,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pwf_pkg::pwf_result_t out_res
);
	import pwf_pkg::*;

	pwf_result_t head_q, tail_q;
	logic        head_vld_q, tail_vld_q;
	logic        take;

	assign take      = head_vld_q && out_ready;
	assign can_load  = !head_vld_q || (!tail_vld_q && out_ready);
	assign out_valid = head_vld_q;
	assign out_res   = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (load) begin
			head_vld_q <= 1'b1;
			tail_vld_q <= (pair.count == 2'd2);
		end else if (take) begin
			head_vld_q <= tail_vld_q;
			tail_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= pair.r0;
			tail_q <= pair.r1;
		end else if (take) begin
			head_q <= tail_q;
		end
	end

endmodule

/* hw/rtl/protobuf_wire_field_parser_core.sv */
// Protobuf wire-format field parser, one message byte per transfer.
// Input bytes are registered, decoded, then held in the result register.
// Throughput: 1 byte per cycle while m_axis_tready is high; a byte yielding
// two results holds the input while the two-entry result register drains.
// Reset: arst_n clears decode state and all valid flags asynchronously.
module protobuf_wire_field_parser_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [pwf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] data_byte
	input  logic                                s_axis_tlast,  // final_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] tag_num, [34:32] wt_code, [98:35] value,
	// [106:99] payload_byte, [109:107] error_code, [111:110] zero
	output logic [pwf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast,  // payload_last
	output logic [pwf_pkg::OUT_TUSER_W-1:0]     m_axis_tuser   // [2:0] kind
);
	import pwf_pkg::*;

	logic        s1_vld_q;
	logic [7:0]  byte_s1;
	logic        final_s1;
	logic        step;
	logic        can_load;
	logic        buf_load;
	pwf_pair_t   pair;
	pwf_result_t res;

	assign step          = s1_vld_q && ((pair.count == 2'd0) || can_load);
	assign buf_load      = step && (pair.count != 2'd0);
	assign s_axis_tready = !s1_vld_q || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_vld_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
		end
	end

	pwf_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.in_byte  (byte_s1),
		.in_final (final_s1),
		.pair     (pair)
	);

	pwf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (buf_load),
		.pair      (pair),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.payload_last;
	assign m_axis_tdata = {2'b00, res.error_code, res.payload_byte, res.value,
		res.wt_code, res.tag_num};

endmodule

/* hw/rtl/pwf_checker.sv */
// Port-level checks for the protobuf wire field parser, bound to the top level.
// Depends on: pwf_pkg, protobuf_wire_field_parser_core_macros.svh.
`include "protobuf_wire_field_parser_core_macros.svh"

module pwf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pwf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic [pwf_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
	import pwf_pkg::*;

	`PWF_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`PWF_ASSERT_IMPLY(a_end_clean, m_axis_tvalid && m_axis_tuser == KIND_END, m_axis_tdata[34:0] == 35'd0, "message end carries field data")
	`PWF_ASSERT_IMPLY(a_last_payload, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_PAYLOAD, "last flag on non-payload result")
	`PWF_ASSERT_IMPLY(a_err_code, m_axis_tvalid && m_axis_tuser != KIND_ERROR, m_axis_tdata[109:107] == ERR_NONE, "error code on non-error result")

endmodule

bind protobuf_wire_field_parser_core pwf_checker u_pwf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

/* tb/sv/tb_protobuf_wire_field_parser_core.sv */
`timescale 1ns / 1ps
// Testbench for protobuf_wire_field_parser_core: streams encoded messages byte by byte,
// predicts the decoded fields in a behavioral decoder and checks every result transfer.
// Depends on pwf_pkg and the core RTL only.
module tb_protobuf_wire_field_parser_core;
	import pwf_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 220;
	localparam logic [63:0] LEN_MAX = (LENGTH_BITS >= 64) ? '1 :
		((64'd1 << LENGTH_BITS) - 64'd1);

	typedef enum logic [1:0] {AT_KEY, AT_VALUE, AT_LENGTH, AT_PAYLOAD} dec_phase_e;
	typedef enum logic [1:0] {RX_READY, RX_RANDOM, RX_PATTERN} rx_mode_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;

	protobuf_wire_field_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	pwf_result_t decoded_q[$];
	logic [7:0]  msg_bytes[$];
	int          errors = 0;
	int          parsed_bytes = 0;
	int          idle_cycles = 0;

	dec_phase_e  dec_phase = AT_KEY;
	logic [63:0] dec_acc = '0;
	int          dec_count = 0;
	logic [31:0] dec_fnum = '0;
	logic [2:0]  dec_wtype = '0;
	logic [63:0] dec_left = '0;
	logic        dec_failed = 1'b0;

	rx_mode_e    rx_mode = RX_READY;
	int          rx_tick = 0;
	logic        hold_active = 1'b0;
	event        hold_off;
	int          tx_gap_max = 0;
	int          burst_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// decoder state after reset and after every final byte
	task automatic clear_decoder();
		dec_phase  = AT_KEY;
		dec_acc    = '0;
		dec_count  = 0;
		dec_fnum   = '0;
		dec_wtype  = '0;
		dec_left   = '0;
		dec_failed = 1'b0;
	endtask

	task automatic push_result(input logic [2:0] kind, input logic [63:0] value,
			input logic [7:0] pbyte, input logic plast, input logic [2:0] code);
		pwf_result_t r;
		r.kind         = kind;
		r.tag_num      = (kind == KIND_END) ? '0 : dec_fnum;
		r.wt_code      = (kind == KIND_END) ? '0 : dec_wtype;
		r.value        = value;
		r.payload_byte = pbyte;
		r.payload_last = plast;
		r.error_code   = code;
		decoded_q.push_back(r);
	endtask

	task automatic raise_error(input logic [2:0] code);
		dec_failed = 1'b1;
		push_result(KIND_ERROR, '0, '0, 1'b0, code);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic fin);
		logic [63:0] v;
		logic        last;
		if (dec_failed) begin
			if (fin)
				clear_decoder();
			return;
		end
		parsed_bytes++;
		if (dec_phase == AT_PAYLOAD) begin
			if (dec_left != 0)
				dec_left--;
			last = (dec_left == 0);
			push_result(KIND_PAYLOAD, '0, b, last, ERR_NONE);
			if (last) begin
				dec_phase = AT_KEY;
				if (fin)
					push_result(KIND_END, '0, '0, 1'b0, ERR_NONE);
			end else if (fin) begin
				raise_error(ERR_TRUNCATED);
			end
			if (fin)
				clear_decoder();
			return;
		end
		dec_acc = dec_acc | ({57'd0, b[6:0]} << ((7 * dec_count) & 63));
		dec_count++;
		if (b[7]) begin
			if (dec_count >= VARINT_MAX_BYTES)
				raise_error(ERR_LONG_VAR);
			else if (fin)
				raise_error(ERR_TRUNCATED);
			if (fin)
				clear_decoder();
			return;
		end
		v = dec_acc;
		dec_acc = '0;
		dec_count = 0;
		case (dec_phase)
			AT_KEY: begin
				dec_fnum  = v[34:3];
				dec_wtype = v[2:0];
				if (dec_fnum == 0) begin
					raise_error(ERR_ZERO_FIELD);
				end else if (dec_wtype == WT_VARINT) begin
					dec_phase = AT_VALUE;
					if (fin)
						raise_error(ERR_TRUNCATED);
				end else if (dec_wtype == WT_LEN) begin
					dec_phase = AT_LENGTH;
					if (fin)
						raise_error(ERR_TRUNCATED);
				end else if (dec_wtype == WT_FIXED64 || dec_wtype == WT_FIXED32) begin
					dec_left = (dec_wtype == WT_FIXED64) ? 64'd8 : 64'd4;
					push_result(KIND_HEADER, dec_left, '0, 1'b0, ERR_NONE);
					dec_phase = AT_PAYLOAD;
					if (fin)
						raise_error(ERR_TRUNCATED);
				end else begin
					raise_error(ERR_WIRE_TYPE);
				end
			end
			AT_VALUE: begin
				push_result(KIND_VARINT, v, '0, 1'b0, ERR_NONE);
				dec_phase = AT_KEY;
				if (fin)
					push_result(KIND_END, '0, '0, 1'b0, ERR_NONE);
			end
			default: begin
				if (v > LEN_MAX) begin
					raise_error(ERR_LEN_BIG);
				end else begin
					push_result(KIND_HEADER, v, '0, 1'b0, ERR_NONE);
					if (v == 0) begin
						dec_phase = AT_KEY;
						if (fin)
							push_result(KIND_END, '0, '0, 1'b0, ERR_NONE);
					end else begin
						dec_left = v;
						dec_phase = AT_PAYLOAD;
						if (fin)
							raise_error(ERR_TRUNCATED);
					end
				end
			end
		endcase
		if (fin)
			clear_decoder();
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pwf_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, got kind %0d tdata %h",
					$time, m_axis_tuser, m_axis_tdata);
				errors++;
			end else begin
				want = decoded_q.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
				check_field("tag_num", 64'(want.tag_num), 64'(m_axis_tdata[31:0]));
				check_field("wt_code", 64'(want.wt_code), 64'(m_axis_tdata[34:32]));
				check_field("value", want.value, m_axis_tdata[98:35]);
				check_field("payload_byte", 64'(want.payload_byte),
					64'(m_axis_tdata[106:99]));
				check_field("payload_last", 64'(want.payload_last), 64'(m_axis_tlast));
				check_field("error_code", 64'(want.error_code),
					64'(m_axis_tdata[109:107]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
				$time, idle_cycles, decoded_q.size());
			$display("tb_protobuf_wire_field_parser_core: done, errors");
			$finish;
		end
	end

	initial begin
		forever begin
			@(hold_off);
			hold_active = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_active = 1'b0;
		end
	end

	always @(negedge clk) begin
		rx_tick++;
		if (hold_active)
			m_axis_tready <= 1'b0;
		else case (rx_mode)
			RX_READY:   m_axis_tready <= 1'b1;
			RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 2) != 0);
			default:    m_axis_tready <= ((rx_tick % 5) < 3);
		endcase
	end

	// one byte per call; holds tvalid high across a burst, drops it for a gap
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, tx_gap_max);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		decode_byte(b, fin);
	endtask

	task automatic send_msg(input int drop);
		int n;
		n = msg_bytes.size() - drop;
		for (int i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		msg_bytes = {};
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pad_to forces a non-minimal encoding of at least that many bytes
	task automatic add_varint(input logic [63:0] v, input int pad_to);
		logic [63:0] rest;
		int count;
		rest = v;
		count = 0;
		forever begin
			count++;
			if (rest[63:7] == 0 && count >= pad_to) begin
				msg_bytes.push_back({1'b0, rest[6:0]});
				break;
			end
			msg_bytes.push_back({1'b1, rest[6:0]});
			rest = rest >> 7;
		end
	endtask

	task automatic add_key(input logic [31:0] fnum, input logic [2:0] wtype);
		add_varint({29'd0, fnum, wtype}, 0);
	endtask

	task automatic add_payload(input int n);
		repeat (n) msg_bytes.push_back(8'($urandom));
	endtask

	function automatic logic [63:0] rand_u64();
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	function automatic logic [31:0] rand_fnum();
		logic [31:0] f;
		f = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 40);
		return (f == 0) ? 32'd1 : f;
	endfunction

	task automatic add_random_field();
		logic [63:0] key;
		int sel;
		int len;
		sel = $urandom_range(0, 99);
		key = {29'd0, rand_fnum(), WT_VARINT};
		if ($urandom_range(0, 9) == 0)
			key[63:35] = 29'($urandom);
		if (sel < 35) begin
			add_varint(key, 0);
			add_varint(rand_u64(), ($urandom_range(0, 9) == 0) ? 10 : 0);
		end else if (sel < 65) begin
			key[2:0] = WT_LEN;
			add_varint(key, 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			add_varint(64'(len), 0);
			add_payload(len);
		end else if (sel < 82) begin
			key[2:0] = WT_FIXED32;
			add_varint(key, 0);
			add_payload(4);
		end else begin
			key[2:0] = WT_FIXED64;
			add_varint(key, 0);
			add_payload(8);
		end
	endtask

	task automatic add_bad_field();
		logic [2:0] wtype;
		case ($urandom_range(0, 3))
			0: add_key('0, 3'($urandom));
			1: begin
				do
					wtype = 3'($urandom);
				while (wtype == WT_VARINT || wtype == WT_FIXED64 || wtype == WT_LEN ||
					wtype == WT_FIXED32);
				add_key(rand_fnum(), wtype);
			end
			2: begin
				add_key(rand_fnum(), WT_VARINT);
				add_varint(rand_u64(), $urandom_range(11, 13));
			end
			default: begin
				add_key(rand_fnum(), WT_LEN);
				add_varint(rand_u64() | (LEN_MAX + 64'd1), 0);
			end
		endcase
	endtask

	task automatic test_field_types();
		rx_mode = RX_RANDOM;
		tx_gap_max = 3;
		add_key(32'd1, WT_VARINT);
		add_varint(64'd150, 0);
		add_key(32'd2, WT_LEN);
		add_varint(64'd2, 0);
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(8'hff);
		add_key(32'd3, WT_FIXED32);
		add_payload(4);
		add_key(32'hffff_ffff, WT_FIXED64);
		add_payload(8);
		send_msg(0);
		add_key(32'd4, WT_VARINT);
		add_varint('1, 0);
		add_key(32'd5, WT_LEN);
		add_varint(64'd0, 0);
		send_msg(0);
		add_key(32'd1, WT_VARINT);
		add_varint(64'd0, 0);
		send_msg(0);
		wait_drained();
	endtask

	task automatic test_key_errors();
		rx_mode = RX_PATTERN;
		add_key('0, WT_LEN);
		add_varint(64'd300, 0);
		send_msg(0);
		for (int wt = 0; wt < 8; wt++) begin
			if (wt != WT_VARINT && wt != WT_FIXED64 && wt != WT_LEN && wt != WT_FIXED32) begin
				add_key(32'd9, 3'(wt));
				add_payload(wt % 3);
				send_msg(0);
			end
		end
		add_key('0, 3'd7);
		send_msg(0);
		wait_drained();
	endtask

	task automatic test_long_varints();
		rx_mode = RX_READY;
		tx_gap_max = 0;
		add_key(32'd6, WT_VARINT);
		add_varint(64'd1, 11);
		add_payload(2);
		send_msg(0);
		add_varint(64'd8, 11);
		send_msg(0);
		add_key(32'd7, WT_VARINT);
		repeat (9) msg_bytes.push_back(8'hff);
		msg_bytes.push_back(8'h7e);
		add_key(32'd7, WT_VARINT);
		add_varint(64'd5, 10);
		send_msg(0);
		wait_drained();
	endtask

	task automatic test_length_limits();
		rx_mode = RX_RANDOM;
		tx_gap_max = 2;
		add_key(32'd8, WT_LEN);
		add_varint(LEN_MAX + 64'd1, 0);
		send_msg(0);
		add_key(32'd8, WT_LEN);
		add_varint('1, 0);
		send_msg(0);
		add_key(32'd8, WT_LEN);
		add_varint(LEN_MAX, 0);
		add_payload(2);
		send_msg(0);
		wait_drained();
	endtask

	task automatic test_truncation();
		rx_mode = RX_PATTERN;
		tx_gap_max = 1;
		add_key(32'd300, WT_VARINT);
		send_msg(1);
		add_key(32'd1, WT_VARINT);
		send_msg(0);
		add_key(32'd2, WT_LEN);
		send_msg(0);
		add_key(32'd3, WT_FIXED32);
		send_msg(0);
		add_key(32'd4, WT_VARINT);
		add_varint(64'd300, 0);
		send_msg(1);
		add_key(32'd5, WT_LEN);
		add_varint(64'd200, 0);
		send_msg(1);
		add_key(32'd6, WT_FIXED64);
		add_payload(8);
		send_msg(4);
		wait_drained();
	endtask

	task automatic test_output_stall();
		rx_mode = RX_READY;
		tx_gap_max = 0;
		-> hold_off;
		repeat (3) begin
			add_key(32'd10, WT_FIXED64);
			add_payload(8);
		end
		add_key(32'd11, WT_VARINT);
		add_varint(rand_u64(), 0);
		send_msg(0);
		wait_drained();
	endtask

	task automatic test_random_messages();
		int start;
		int sel;
		int drop;
		start = parsed_bytes;
		while (parsed_bytes - start < RANDOM_BYTES) begin
			if ($urandom_range(0, 5) == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0: tx_gap_max = 0;
					1: tx_gap_max = 3;
					default: tx_gap_max = 12;
				endcase
			end
			sel = $urandom_range(0, 99);
			drop = 0;
			if (sel < 85) begin
				repeat ($urandom_range(1, 4)) add_random_field();
				if (sel >= 72) begin
					add_bad_field();
					if ($urandom_range(0, 1) == 0)
						add_random_field();
				end else if ($urandom_range(0, 9) == 0 && msg_bytes.size() > 1) begin
					drop = $urandom_range(1, msg_bytes.size() - 1);
				end
			end else begin
				repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
			end
			send_msg(drop);
		end
		wait_drained();
	endtask

	initial begin
		clear_decoder();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_field_types();
		test_key_errors();
		test_long_varints();
		test_length_limits();
		test_truncation();
		test_output_stall();
		test_random_messages();
		if (errors == 0)
			$display("tb_protobuf_wire_field_parser_core: done, clean");
		else
			$display("tb_protobuf_wire_field_parser_core: done, errors");
		$finish;
	end

endmodule
